// ===== hdl/jtl_pkg.sv =====
// Package for the JSON token lexer: request types, token and error codes, helpers.
package jtl_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned LENGTH_BITS   = 16;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = '1;

  // Characters that steer the lexer
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_VTAB      = 8'h0B;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_EXP_LOW   = 8'h65;
  localparam logic [7:0] CH_EXP_UP    = 8'h45;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_LOW_B     = 8'h62;
  localparam logic [7:0] CH_LOW_F     = 8'h66;
  localparam logic [7:0] CH_LOW_N     = 8'h6E;
  localparam logic [7:0] CH_LOW_R     = 8'h72;
  localparam logic [7:0] CH_LOW_T     = 8'h74;
  localparam logic [7:0] CH_LOW_U     = 8'h75;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_COLON     = 8'h3A;

  typedef enum logic [0:0] {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    TK_INT      = 4'd0,
    TK_FLOAT    = 4'd1,
    TK_LBRACE   = 4'd2,
    TK_RBRACE   = 4'd3,
    TK_LBRACKET = 4'd4,
    TK_RBRACKET = 4'd5,
    TK_COMMA    = 4'd6,
    TK_COLON    = 4'd7,
    TK_NULL     = 4'd8,
    TK_TRUE     = 4'd9,
    TK_FALSE    = 4'd10,
    TK_STRING   = 4'd11,
    TK_END      = 4'd12,
    TK_ERROR    = 4'd13
  } token_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_MINUS  = 3'd1,
    ERR_NO_DIGIT   = 3'd2,
    ERR_BAD_LIT    = 3'd3,
    ERR_UNTERM_STR = 3'd4,
    ERR_BAD_ESCAPE = 3'd5,
    ERR_BAD_CHAR   = 3'd6
  } error_code_t;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]               token_kind;
    logic [2:0]               error_code;
    logic [POSITION_BITS-1:0] token_line;
    logic [POSITION_BITS-1:0] token_column;
    logic [LENGTH_BITS-1:0]   token_length;
    logic                     last_of_run;
  } out_t;

  // Literal word select: null, true, false
  localparam logic [1:0] LIT_NULL  = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_FALSE = 2'd2;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic [2:0] lit_size(input logic [1:0] w);
    logic [2:0] s;
    case (w)
      LIT_FALSE: s = 3'd5;
      default:   s = 3'd4;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      LIT_NULL: begin
        case (p)
          3'd0:    c = 8'h6E;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        case (p)
          3'd0:    c = 8'h74;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
      default: begin
        case (p)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic out_t make_res(input token_kind_t kind, input error_code_t err,
                                    input logic [POSITION_BITS-1:0] line,
                                    input logic [POSITION_BITS-1:0] col,
                                    input logic [LENGTH_BITS-1:0] len);
    out_t r;
    r.token_kind   = kind;
    r.error_code   = err;
    r.token_line   = line;
    r.token_column = col;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

// ===== hdl/json_token_lexer.sv =====
// JSON token lexer: byte-serial tokenizer with position tracking and a result queue.
// Each result is written into the result queue when its request is accepted; out_data shows the queue head.
// Throughput: one request per cycle while in_stall is low; a request can yield two results,
//   and in_stall rises while the four-entry result queue holds three or more.
// Reset (rst, synchronous): lexer idle, line and column 1, queue empty, halt cleared.
// After an error result the lexer accepts requests and drops them until reset.
module json_token_lexer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  jtl_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output jtl_pkg::out_t  out_data
);

  typedef enum logic [12:0] {
    M_IDLE       = 13'b0000000000001,
    M_MINUS      = 13'b0000000000010,
    M_INT        = 13'b0000000000100,
    M_FRAC_FIRST = 13'b0000000001000,
    M_FRAC       = 13'b0000000010000,
    M_EXP_SIGN   = 13'b0000000100000,
    M_EXP_FIRST  = 13'b0000001000000,
    M_EXP        = 13'b0000010000000,
    M_LIT_NULL   = 13'b0000100000000,
    M_LIT_TRUE   = 13'b0001000000000,
    M_LIT_FALSE  = 13'b0010000000000,
    M_STR        = 13'b0100000000000,
    M_ESC        = 13'b1000000000000
  } mode_t;

  localparam int unsigned PB = jtl_pkg::POSITION_BITS;
  localparam int unsigned LB = jtl_pkg::LENGTH_BITS;

  // Lexer state
  mode_t             mode, mode_next;
  logic [2:0]        prog, prog_next;
  logic [PB-1:0]     line, line_next;
  logic [PB-1:0]     col, col_next;
  logic [PB-1:0]     sline, sline_next;
  logic [PB-1:0]     scol, scol_next;
  logic [LB-1:0]     len, len_next;
  logic              flt, flt_next;
  logic              halted, halted_next;

  // Result queue
  jtl_pkg::out_t     q [4];
  logic [1:0]        rd_ptr, wr_ptr;
  logic [2:0]        count;

  jtl_pkg::out_t     res [2];
  logic [1:0]        nres;
  logic              accept, pop;

  logic [7:0]        b;
  logic              do_idle;
  logic [1:0]        lit_w;

  assign accept    = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;
  assign in_stall  = (count >= 3'd3);
  assign out_valid = (count != 3'd0);
  assign out_data  = q[rd_ptr];
  assign b         = in_data.text_byte;

  always_comb begin
    unique case (mode)
      M_LIT_TRUE:  lit_w = jtl_pkg::LIT_TRUE;
      M_LIT_FALSE: lit_w = jtl_pkg::LIT_FALSE;
      default:     lit_w = jtl_pkg::LIT_NULL;
    endcase
  end

  // Lex one request: state update and up to two results
  always_comb begin
    mode_next   = mode;
    prog_next   = prog;
    line_next   = line;
    col_next    = col;
    sline_next  = sline;
    scol_next   = scol;
    len_next    = len;
    flt_next    = flt;
    halted_next = halted;
    res[0]      = '0;
    res[1]      = '0;
    nres        = 2'd0;
    do_idle     = 1'b0;

    if (!halted) begin
      if (in_data.action == jtl_pkg::ACT_END) begin
        // End of input: close or reject the open token
        mode_next = M_IDLE;
        unique case (mode)
          M_IDLE: ;
          M_INT, M_FRAC, M_EXP: begin
            res[0] = jtl_pkg::make_res(flt ? jtl_pkg::TK_FLOAT : jtl_pkg::TK_INT,
                                       jtl_pkg::ERR_NONE, sline, scol, len);
            nres = 2'd1;
            flt_next = 1'b0;
            prog_next = 3'd0;
          end
          M_MINUS: begin
            res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_MINUS,
                                       sline, scol, len);
            nres = 2'd1;
            halted_next = 1'b1;
          end
          M_FRAC_FIRST, M_EXP_SIGN, M_EXP_FIRST: begin
            res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_NO_DIGIT,
                                       sline, scol, len);
            nres = 2'd1;
            halted_next = 1'b1;
          end
          M_LIT_NULL, M_LIT_TRUE, M_LIT_FALSE: begin
            res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_LIT,
                                       sline, scol, len);
            nres = 2'd1;
            halted_next = 1'b1;
          end
          M_STR: begin
            res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_UNTERM_STR,
                                       sline, scol, len);
            nres = 2'd1;
            halted_next = 1'b1;
          end
          default: begin
            res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_ESCAPE,
                                       sline, scol, len);
            nres = 2'd1;
            halted_next = 1'b1;
          end
        endcase
        if (!halted_next) begin
          res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_END, jtl_pkg::ERR_NONE,
                                           line, col, '0);
          nres = nres + 2'd1;
        end
      end else begin
        unique case (mode)
          M_IDLE: do_idle = 1'b1;
          M_MINUS: begin
            len_next = jtl_pkg::len_inc(len);
            col_next = jtl_pkg::pos_inc(col);
            if (jtl_pkg::is_digit(b)) begin
              mode_next = M_INT;
            end else begin
              res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_MINUS,
                                         sline, scol, len_next);
              nres = 2'd1;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_INT, M_FRAC, M_EXP: begin
            if (jtl_pkg::is_digit(b)) begin
              len_next = jtl_pkg::len_inc(len);
              col_next = jtl_pkg::pos_inc(col);
            end else if (b == jtl_pkg::CH_DOT && mode == M_INT) begin
              len_next = jtl_pkg::len_inc(len);
              col_next = jtl_pkg::pos_inc(col);
              flt_next = 1'b1;
              mode_next = M_FRAC_FIRST;
            end else if ((b == jtl_pkg::CH_EXP_LOW || b == jtl_pkg::CH_EXP_UP) &&
                         mode != M_EXP) begin
              len_next = jtl_pkg::len_inc(len);
              col_next = jtl_pkg::pos_inc(col);
              flt_next = 1'b1;
              mode_next = M_EXP_SIGN;
            end else begin
              // Close the number, then lex this byte from idle
              res[0] = jtl_pkg::make_res(flt ? jtl_pkg::TK_FLOAT : jtl_pkg::TK_INT,
                                         jtl_pkg::ERR_NONE, sline, scol, len);
              nres = 2'd1;
              mode_next = M_IDLE;
              flt_next = 1'b0;
              prog_next = 3'd0;
              do_idle = 1'b1;
            end
          end
          M_FRAC_FIRST, M_EXP_FIRST: begin
            len_next = jtl_pkg::len_inc(len);
            col_next = jtl_pkg::pos_inc(col);
            if (jtl_pkg::is_digit(b)) begin
              mode_next = (mode == M_FRAC_FIRST) ? M_FRAC : M_EXP;
            end else begin
              res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_NO_DIGIT,
                                         sline, scol, len_next);
              nres = 2'd1;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_EXP_SIGN: begin
            len_next = jtl_pkg::len_inc(len);
            col_next = jtl_pkg::pos_inc(col);
            if (b == jtl_pkg::CH_PLUS || b == jtl_pkg::CH_MINUS) begin
              mode_next = M_EXP_FIRST;
            end else if (jtl_pkg::is_digit(b)) begin
              mode_next = M_EXP;
            end else begin
              res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_NO_DIGIT,
                                         sline, scol, len_next);
              nres = 2'd1;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_LIT_NULL, M_LIT_TRUE, M_LIT_FALSE: begin
            len_next = jtl_pkg::len_inc(len);
            col_next = jtl_pkg::pos_inc(col);
            if (prog < jtl_pkg::lit_size(lit_w) && b == jtl_pkg::lit_char(lit_w, prog)) begin
              prog_next = prog + 3'd1;
              if (prog_next >= jtl_pkg::lit_size(lit_w)) begin
                res[0] = jtl_pkg::make_res(
                  (lit_w == jtl_pkg::LIT_NULL) ? jtl_pkg::TK_NULL :
                  (lit_w == jtl_pkg::LIT_TRUE) ? jtl_pkg::TK_TRUE : jtl_pkg::TK_FALSE,
                  jtl_pkg::ERR_NONE, sline, scol, len_next);
                nres = 2'd1;
                mode_next = M_IDLE;
                flt_next = 1'b0;
                prog_next = 3'd0;
              end
            end else begin
              res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_LIT,
                                         sline, scol, len_next);
              nres = 2'd1;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end
          end
          M_STR: begin
            len_next = jtl_pkg::len_inc(len);
            col_next = jtl_pkg::pos_inc(col);
            if (b == jtl_pkg::CH_QUOTE) begin
              res[0] = jtl_pkg::make_res(jtl_pkg::TK_STRING, jtl_pkg::ERR_NONE,
                                         sline, scol, len_next);
              nres = 2'd1;
              mode_next = M_IDLE;
              flt_next = 1'b0;
              prog_next = 3'd0;
            end else if (b == jtl_pkg::CH_BACKSLASH) begin
              mode_next = M_ESC;
            end
          end
          default: begin
            // Escape: check the character after the backslash
            len_next = jtl_pkg::len_inc(len);
            col_next = jtl_pkg::pos_inc(col);
            if (b == jtl_pkg::CH_QUOTE || b == jtl_pkg::CH_BACKSLASH ||
                b == jtl_pkg::CH_SLASH || b == jtl_pkg::CH_LOW_B ||
                b == jtl_pkg::CH_LOW_F || b == jtl_pkg::CH_LOW_N ||
                b == jtl_pkg::CH_LOW_R || b == jtl_pkg::CH_LOW_T ||
                b == jtl_pkg::CH_LOW_U) begin
              mode_next = M_STR;
            end else begin
              res[0] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_ESCAPE,
                                         sline, scol, len_next);
              nres = 2'd1;
              halted_next = 1'b1;
              mode_next = M_IDLE;
            end
          end
        endcase

        // Lex a byte from idle: blanks, or the first byte of a token
        if (do_idle) begin
          if (b == jtl_pkg::CH_NEWLINE) begin
            line_next = jtl_pkg::pos_inc(line);
            col_next  = {{(PB-1){1'b0}}, 1'b1};
          end else if (b == jtl_pkg::CH_SPACE || b == jtl_pkg::CH_TAB ||
                       b == jtl_pkg::CH_VTAB || b == jtl_pkg::CH_FORMFEED ||
                       b == jtl_pkg::CH_RETURN) begin
            col_next = jtl_pkg::pos_inc(col);
          end else begin
            sline_next = line;
            scol_next  = col;
            len_next   = {{(LB-1){1'b0}}, 1'b1};
            col_next   = jtl_pkg::pos_inc(col);
            flt_next   = 1'b0;
            prog_next  = 3'd1;
            mode_next  = M_IDLE;
            if (b == jtl_pkg::CH_MINUS) begin
              mode_next = M_MINUS;
            end else if (jtl_pkg::is_digit(b)) begin
              mode_next = M_INT;
            end else if (b == jtl_pkg::CH_LOW_N) begin
              mode_next = M_LIT_NULL;
            end else if (b == jtl_pkg::CH_LOW_T) begin
              mode_next = M_LIT_TRUE;
            end else if (b == jtl_pkg::CH_LOW_F) begin
              mode_next = M_LIT_FALSE;
            end else if (b == jtl_pkg::CH_QUOTE) begin
              mode_next = M_STR;
            end else begin
              prog_next = 3'd0;
              case (b)
                jtl_pkg::CH_LBRACE:
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_LBRACE, jtl_pkg::ERR_NONE,
                                                   line, col, len_next);
                jtl_pkg::CH_RBRACE:
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_RBRACE, jtl_pkg::ERR_NONE,
                                                   line, col, len_next);
                jtl_pkg::CH_LBRACKET:
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_LBRACKET, jtl_pkg::ERR_NONE,
                                                   line, col, len_next);
                jtl_pkg::CH_RBRACKET:
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_RBRACKET, jtl_pkg::ERR_NONE,
                                                   line, col, len_next);
                jtl_pkg::CH_COMMA:
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_COMMA, jtl_pkg::ERR_NONE,
                                                   line, col, len_next);
                jtl_pkg::CH_COLON:
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_COLON, jtl_pkg::ERR_NONE,
                                                   line, col, len_next);
                default: begin
                  res[nres[0]] = jtl_pkg::make_res(jtl_pkg::TK_ERROR, jtl_pkg::ERR_BAD_CHAR,
                                                   line, col, len_next);
                  halted_next = 1'b1;
                  prog_next = 3'd1;
                end
              endcase
              nres = nres + 2'd1;
            end
          end
        end
      end
    end

    // Flag the final result of this request
    if (nres != 2'd0) begin
      res[nres[1]].last_of_run = 1'b1;
    end
  end

  // Advance lexer state on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      prog   <= 3'd0;
      line   <= {{(PB-1){1'b0}}, 1'b1};
      col    <= {{(PB-1){1'b0}}, 1'b1};
      sline  <= {{(PB-1){1'b0}}, 1'b1};
      scol   <= {{(PB-1){1'b0}}, 1'b1};
      len    <= '0;
      flt    <= 1'b0;
      halted <= 1'b0;
    end else if (accept) begin
      mode   <= mode_next;
      prog   <= prog_next;
      line   <= line_next;
      col    <= col_next;
      sline  <= sline_next;
      scol   <= scol_next;
      len    <= len_next;
      flt    <= flt_next;
      halted <= halted_next;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (accept) begin
        wr_ptr <= wr_ptr + nres;
      end
      count <= count + (accept ? {1'b0, nres} : 3'd0) - {2'b00, pop};
    end
  end

  // Write results into the queue
  always_ff @(posedge clk) begin
    if (accept && nres != 2'd0) begin
      q[wr_ptr] <= res[0];
      if (nres == 2'd2) begin
        q[wr_ptr + 2'd1] <= res[1];
      end
    end
  end

endmodule

// ===== bench/tb_json_token_lexer.sv =====
// Self-checking testbench for json_token_lexer: random JSON text against a token predictor.
import jtl_pkg::*;

typedef enum int {
  SCAN_IDLE, SCAN_MINUS, SCAN_INT, SCAN_FRAC_FIRST, SCAN_FRAC, SCAN_EXP_SIGN,
  SCAN_EXP_FIRST, SCAN_EXP, SCAN_NULL, SCAN_TRUE, SCAN_FALSE, SCAN_STR, SCAN_ESC
} scan_mode_t;

class token_scoreboard;
  out_t        tokens_due[$];
  int unsigned mismatches;

  // Lexer state as the block should hold it
  scan_mode_t                  mode;
  int unsigned                 progress;
  logic [POSITION_BITS-1:0]    line_no;
  logic [POSITION_BITS-1:0]    col_no;
  logic [POSITION_BITS-1:0]    first_line;
  logic [POSITION_BITS-1:0]    first_col;
  logic [LENGTH_BITS-1:0]      span;
  bit                          is_float;
  bit                          halted;

  function new();
    mode       = SCAN_IDLE;
    progress   = 0;
    line_no    = 1;
    col_no     = 1;
    first_line = 1;
    first_col  = 1;
    span       = '0;
    is_float   = 1'b0;
    halted     = 1'b0;
    mismatches = 0;
  endfunction

  function logic [POSITION_BITS-1:0] bump_pos(logic [POSITION_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function bit numeral(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function void queue_token(token_kind_t kind, error_code_t code,
                            logic [POSITION_BITS-1:0] line, logic [POSITION_BITS-1:0] col,
                            logic [LENGTH_BITS-1:0] len);
    out_t r;
    r.token_kind   = kind;
    r.error_code   = code;
    r.token_line   = line;
    r.token_column = col;
    r.token_length = len;
    r.last_of_run  = 1'b0;
    tokens_due = {tokens_due, r};
  endfunction

  // Count one byte of the current token
  function void advance();
    if (span != LEN_MAX) span = span + 1'b1;
    col_no = bump_pos(col_no);
  endfunction

  function void close_token(token_kind_t kind);
    queue_token(kind, ERR_NONE, first_line, first_col, span);
    mode     = SCAN_IDLE;
    is_float = 1'b0;
    progress = 0;
  endfunction

  function void abort_token(error_code_t code);
    queue_token(TK_ERROR, code, first_line, first_col, span);
    halted = 1'b1;
    mode   = SCAN_IDLE;
  endfunction

  // Lex a byte seen between tokens
  function void open_token(logic [7:0] b);
    if (b == CH_NEWLINE) begin
      line_no = bump_pos(line_no);
      col_no  = 1;
      return;
    end
    if (b inside {CH_SPACE, CH_TAB, CH_VTAB, CH_FORMFEED, CH_RETURN}) begin
      col_no = bump_pos(col_no);
      return;
    end
    first_line = line_no;
    first_col  = col_no;
    span       = '0;
    is_float   = 1'b0;
    progress   = 1;
    advance();
    if (numeral(b)) begin
      mode = SCAN_INT;
      return;
    end
    case (b)
      CH_MINUS:    mode = SCAN_MINUS;
      CH_LOW_N:    mode = SCAN_NULL;
      CH_LOW_T:    mode = SCAN_TRUE;
      CH_LOW_F:    mode = SCAN_FALSE;
      CH_QUOTE:    mode = SCAN_STR;
      CH_LBRACE:   close_token(TK_LBRACE);
      CH_RBRACE:   close_token(TK_RBRACE);
      CH_LBRACKET: close_token(TK_LBRACKET);
      CH_RBRACKET: close_token(TK_RBRACKET);
      CH_COMMA:    close_token(TK_COMMA);
      CH_COLON:    close_token(TK_COLON);
      default:     abort_token(ERR_BAD_CHAR);
    endcase
  endfunction

  // A number ends on the byte after it; that byte starts the next token
  function void split_number(logic [7:0] b);
    close_token(is_float ? TK_FLOAT : TK_INT);
    open_token(b);
  endfunction

  function void match_literal(logic [7:0] b);
    string       word;
    token_kind_t kind;
    case (mode)
      SCAN_NULL: begin
        word = "null";
        kind = TK_NULL;
      end
      SCAN_TRUE: begin
        word = "true";
        kind = TK_TRUE;
      end
      default: begin
        word = "false";
        kind = TK_FALSE;
      end
    endcase
    advance();
    if (progress < word.len() && b == word[progress]) begin
      progress++;
      if (progress >= word.len()) close_token(kind);
    end else begin
      abort_token(ERR_BAD_LIT);
    end
  endfunction

  function void scan_byte(logic [7:0] b);
    case (mode)
      SCAN_IDLE: open_token(b);
      SCAN_MINUS: begin
        advance();
        if (numeral(b)) mode = SCAN_INT;
        else abort_token(ERR_BAD_MINUS);
      end
      SCAN_INT: begin
        if (numeral(b)) begin
          advance();
        end else if (b == CH_DOT) begin
          advance();
          is_float = 1'b1;
          mode     = SCAN_FRAC_FIRST;
        end else if (b == CH_EXP_LOW || b == CH_EXP_UP) begin
          advance();
          is_float = 1'b1;
          mode     = SCAN_EXP_SIGN;
        end else begin
          split_number(b);
        end
      end
      SCAN_FRAC_FIRST: begin
        advance();
        if (numeral(b)) mode = SCAN_FRAC;
        else abort_token(ERR_NO_DIGIT);
      end
      SCAN_FRAC: begin
        if (numeral(b)) begin
          advance();
        end else if (b == CH_EXP_LOW || b == CH_EXP_UP) begin
          advance();
          mode = SCAN_EXP_SIGN;
        end else begin
          split_number(b);
        end
      end
      SCAN_EXP_SIGN: begin
        advance();
        if (b == CH_PLUS || b == CH_MINUS) mode = SCAN_EXP_FIRST;
        else if (numeral(b)) mode = SCAN_EXP;
        else abort_token(ERR_NO_DIGIT);
      end
      SCAN_EXP_FIRST: begin
        advance();
        if (numeral(b)) mode = SCAN_EXP;
        else abort_token(ERR_NO_DIGIT);
      end
      SCAN_EXP: begin
        if (numeral(b)) advance();
        else split_number(b);
      end
      SCAN_NULL, SCAN_TRUE, SCAN_FALSE: match_literal(b);
      SCAN_STR: begin
        advance();
        if (b == CH_QUOTE) close_token(TK_STRING);
        else if (b == CH_BACKSLASH) mode = SCAN_ESC;
      end
      default: begin
        advance();
        if (b inside {CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOW_B, CH_LOW_F, CH_LOW_N,
                      CH_LOW_R, CH_LOW_T, CH_LOW_U})
          mode = SCAN_STR;
        else
          abort_token(ERR_BAD_ESCAPE);
      end
    endcase
  endfunction

  // Predict the tokens of one accepted request
  function void note_request(in_t req);
    int   due_before;
    out_t tail;
    due_before = tokens_due.size();
    if (halted) return;
    if (req.action == ACT_END) begin
      case (mode)
        SCAN_IDLE: begin
        end
        SCAN_INT, SCAN_FRAC, SCAN_EXP: close_token(is_float ? TK_FLOAT : TK_INT);
        SCAN_MINUS: abort_token(ERR_BAD_MINUS);
        SCAN_FRAC_FIRST, SCAN_EXP_SIGN, SCAN_EXP_FIRST: abort_token(ERR_NO_DIGIT);
        SCAN_NULL, SCAN_TRUE, SCAN_FALSE: abort_token(ERR_BAD_LIT);
        SCAN_STR: abort_token(ERR_UNTERM_STR);
        default: abort_token(ERR_BAD_ESCAPE);
      endcase
      if (!halted) queue_token(TK_END, ERR_NONE, line_no, col_no, '0);
    end else begin
      scan_byte(req.text_byte);
    end
    // Flag the final token of this request
    if (tokens_due.size() > due_before) begin
      tail = tokens_due.pop_back();
      tail.last_of_run = 1'b1;
      tokens_due = {tokens_due, tail};
    end
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function void check_token(out_t got);
    out_t want;
    if (tokens_due.size() == 0) begin
      $error("token with none due: kind %0d line %0d column %0d length %0d",
             got.token_kind, got.token_line, got.token_column, got.token_length);
      mismatches++;
      return;
    end
    want = tokens_due.pop_front();
    compare_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
    compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
    compare_field("token_line", 32'(want.token_line), 32'(got.token_line));
    compare_field("token_column", 32'(want.token_column), 32'(got.token_column));
    compare_field("token_length", 32'(want.token_length), 32'(got.token_length));
    compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
  endfunction
endclass

module tb_json_token_lexer;

  localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_NEWLINE, CH_RETURN, CH_VTAB,
                                        CH_FORMFEED};
  localparam logic [7:0] PUNCT [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACKET, CH_RBRACKET,
                                       CH_COMMA, CH_COLON};
  localparam logic [7:0] ESCAPES [9] = '{CH_QUOTE, CH_BACKSLASH, CH_SLASH, CH_LOW_B,
                                         CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_LOW_U};

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  token_scoreboard sb;

  int unsigned accepted      = 0;
  int unsigned burst_left    = 0;
  bit          spread_gaps   = 1'b1;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned style_left    = 0;
  int unsigned stall_style   = 0;
  logic [7:0]  text_q[$];

  json_token_lexer i_dut (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data
  );

  always #5 clk = ~clk;

  // Check accepted tokens and drive the output stall pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_token(out_data);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = $urandom_range(40, 80);
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 120);
      end
      style_left--;
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) < 5);
      endcase
    end
  end

  // Offer one request, in bursts with random gaps, and hold it until accepted
  task automatic send_request(input action_t act, input logic [7:0] b);
    in_t         req;
    int unsigned gap;
    req.action    = act;
    req.text_byte = b;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = spread_gaps ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    accepted++;
    sb.note_request(req);
  endtask

  task automatic flush_text();
    logic [7:0] b;
    while (text_q.size() != 0) begin
      b = text_q.pop_front();
      send_request(ACT_BYTE, b);
    end
  endtask

  // Drop valid; call only right before time advances
  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.tokens_due.size() != 0);
  endtask

  // Append one byte to the pending text
  function automatic void put_byte(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void add_blank();
    repeat ($urandom_range(1, 2)) put_byte(BLANKS[$urandom_range(0, 5)]);
  endfunction

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Printable byte that neither closes a string nor starts an escape
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_QUOTE || c == CH_BACKSLASH) c = CH_LOW_U;
    return c;
  endfunction

  initial begin
    #8_000_000;
    $display("** json_token_lexer: FAILED **");
    $finish;
  end

  initial begin
    int unsigned choice;
    bit          prev_number;
    bit          next_number;
    bit          held;
    bit          drained;
    bit          end_mark;

    sb          = new();
    prev_number = 1'b0;
    held        = 1'b0;
    drained     = 1'b0;
    end_mark    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme bytes and an escaped quote inside a string
    put_byte(CH_QUOTE);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_BACKSLASH);
    put_byte(CH_QUOTE);
    put_byte(CH_QUOTE);
    // Newline, vertical tab, full float ending on a brace, int closed by end of input
    put_byte(CH_NEWLINE);
    put_byte(CH_VTAB);
    add_text("-4.5e+1}7");
    flush_text();
    send_request(ACT_END, 8'hA5);
    add_text("[null");
    flush_text();

    // Random well-formed token stream
    while (accepted < 410) begin
      choice      = $urandom_range(0, 11);
      next_number = (choice < 4);
      // Keep two numbers apart so they do not merge
      if (prev_number && next_number) begin
        if ($urandom_range(0, 3) == 0) put_byte(CH_COMMA);
        else add_blank();
      end else if ($urandom_range(0, 2) == 0) begin
        add_blank();
      end
      case (choice)
        0, 1, 2, 3: begin
          if ($urandom_range(0, 2) == 0) put_byte(CH_MINUS);
          repeat ($urandom_range(1, 4)) put_byte(random_digit());
          if ($urandom_range(0, 1) == 1) begin
            put_byte(CH_DOT);
            repeat ($urandom_range(1, 3)) put_byte(random_digit());
          end
          if ($urandom_range(0, 2) == 0) begin
            put_byte(($urandom_range(0, 1) == 1) ? CH_EXP_LOW : CH_EXP_UP);
            case ($urandom_range(0, 2))
              0: put_byte(CH_PLUS);
              1: put_byte(CH_MINUS);
              default: begin
              end
            endcase
            repeat ($urandom_range(1, 3)) put_byte(random_digit());
          end
        end
        4, 5: begin
          put_byte(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 5))
              0: put_byte(8'($urandom_range(128, 255)));
              1: put_byte(8'($urandom_range(0, 31)));
              2: begin
                put_byte(CH_BACKSLASH);
                put_byte(ESCAPES[$urandom_range(0, 8)]);
              end
              default: put_byte(plain_char());
            endcase
          end
          put_byte(CH_QUOTE);
        end
        6: begin
          case ($urandom_range(0, 2))
            0:       add_text("null");
            1:       add_text("true");
            default: add_text("false");
          endcase
        end
        7, 8, 9: put_byte(PUNCT[$urandom_range(0, 5)]);
        default: begin
          flush_text();
          send_request(ACT_END, 8'($urandom_range(0, 255)));
        end
      endcase
      flush_text();
      prev_number = next_number;

      // Hold the output long enough to back up the input
      if (!held && accepted >= 150) begin
        held = 1'b1;
        hold_requests++;
      end
      // Pause the input until every due token is out
      if (!drained && accepted >= 320) begin
        drained = 1'b1;
        idle_input();
        wait_drained();
      end
    end

    // Finish with one error, picked at random; later requests must be dropped
    case ($urandom_range(0, 11))
      0:  add_text("-x");
      1: begin
        add_text("-");
        end_mark = 1'b1;
      end
      2:  add_text("1.x");
      3: begin
        add_text("1e");
        end_mark = 1'b1;
      end
      4:  add_text("2e+a");
      5:  add_text("trux");
      6: begin
        add_text("nul");
        end_mark = 1'b1;
      end
      7: begin
        add_text("\"ab");
        end_mark = 1'b1;
      end
      8:  add_text("\"\\q");
      9: begin
        add_text("\"\\");
        end_mark = 1'b1;
      end
      10: put_byte(8'($urandom_range(128, 255)));
      default: put_byte(8'($urandom_range(0, 8)));
    endcase
    flush_text();
    if (end_mark) send_request(ACT_END, 8'($urandom_range(0, 255)));
    repeat (12) send_request(action_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    idle_input();
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.tokens_due.size() == 0)
      $display("** json_token_lexer: PASSED **");
    else
      $display("** json_token_lexer: FAILED **");
    $finish;
  end

endmodule
